// ===== hw/rtl/xtea_ctr_pkg.sv =====
package xtea_ctr_pkg;

  localparam int unsigned ROUND_COUNT_DEF = 32;
  localparam logic [31:0] DELTA           = 32'h9E3779B9;
  localparam logic [31:0] POS_MAX         = 32'hFFFFFFFF;
  localparam int unsigned KEY_SHIFT       = 11;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [31:0] offset;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       error;
    logic       last_out;
  } out_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] sel;
    logic       error;
    logic       last;
  } side_t;

  typedef struct packed {
    logic [31:0] v0;
    logic [31:0] v1;
    side_t       side;
  } stage_t;

  typedef logic [3:0][31:0] key_t;

  // round constant seen by half-round step: the second half uses the advanced sum
  function automatic logic [31:0] step_sum(int unsigned step);
    logic [31:0] rnd;
    rnd = 32'((step >> 1) + (step & 1));
    return rnd * DELTA;
  endfunction

  function automatic logic [1:0] step_key_sel(int unsigned step);
    logic [31:0] s;
    s = step_sum(step);
    return ((step & 1) != 0) ? 2'(s >> KEY_SHIFT) : s[1:0];
  endfunction

endpackage

// ===== hw/rtl/xtea_ctr_front.sv =====
module xtea_ctr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xtea_ctr_pkg::in_t    in_data,
  input  logic [63:0]          nonce,
  input  logic                 ready_next,
  output logic                 valid,
  output xtea_ctr_pkg::stage_t dn
);
  import xtea_ctr_pkg::*;

  logic [31:0] byte_position;
  logic        overflowed;
  logic [31:0] pos;
  logic        err;
  logic        ready;
  logic        accept;
  logic [63:0] counter;

  assign ready    = !valid || ready_next;
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  assign pos     = in_data.start_req ? in_data.offset : byte_position;
  assign err     = in_data.start_req ? 1'b0 : overflowed;
  assign counter = nonce + {35'd0, pos[31:3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      overflowed    <= 1'b0;
      valid         <= 1'b0;
    end else begin
      if (accept) begin
        byte_position <= err ? byte_position : pos + 32'd1;
        overflowed    <= err || (pos == POS_MAX);
      end
      if (ready) begin
        valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dn.v0             <= counter[63:32];
      dn.v1             <= counter[31:0];
      dn.side.data_byte <= in_data.data_byte;
      dn.side.sel       <= pos[2:0];
      dn.side.error     <= err;
      dn.side.last      <= in_data.last_in;
    end
  end

endmodule

// ===== hw/rtl/xtea_ctr_cell.sv =====
module xtea_ctr_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  xtea_ctr_pkg::key_t   key,
  input  logic                 up_valid,
  input  xtea_ctr_pkg::stage_t up,
  input  logic                 ready_next,
  output logic                 ready,
  output logic                 valid,
  output xtea_ctr_pkg::stage_t dn
);
  import xtea_ctr_pkg::*;

  localparam logic [31:0] SUM  = step_sum(STEP);
  localparam logic [1:0]  KSEL = step_key_sel(STEP);
  localparam bit          SECOND = (STEP & 1) != 0;

  logic [31:0] src;
  logic [31:0] mix;
  logic [31:0] f;
  stage_t      nxt;

  assign src = SECOND ? up.v0 : up.v1;
  assign mix = SUM + key[KSEL];
  assign f   = ((src << 4) ^ (src >> 5)) + src;

  always_comb begin
    nxt = up;
    if (SECOND) begin
      nxt.v1 = up.v1 + (f ^ mix);
    end else begin
      nxt.v0 = up.v0 + (f ^ mix);
    end
  end

  assign ready = !valid || ready_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      dn <= nxt;
    end
  end

endmodule

// ===== hw/rtl/xtea_ctr_out.sv =====
module xtea_ctr_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  input  xtea_ctr_pkg::stage_t up,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xtea_ctr_pkg::out_t   out_data
);
  import xtea_ctr_pkg::*;

  logic [63:0] block;
  logic [2:0]  rsel;
  logic [7:0]  ks;

  assign block = {up.v0, up.v1};
  assign rsel  = ~up.side.sel;
  assign ks    = block[{rsel, 3'b000} +: 8];
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      out_data.out_byte <= up.side.error ? 8'd0 : (up.side.data_byte ^ ks);
      out_data.error    <= up.side.error;
      out_data.last_out <= up.side.last;
    end
  end

endmodule

// ===== hw/rtl/xtea_ctr_keystream_cipher_core.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | in_data  (data_byte, start_req, offset, last_in)
// out     | output    | out_valid / out_stall | out_data (out_byte, error, last_out)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte transfer per cycle sustained while out_stall is low; each byte passes the front register,
// the chain of half-round cells and the output register in turn, each byte computing its own block.
// rst is synchronous: clears all valid flags, the byte position, overflow flag and the key and nonce registers.
// out_stall holds the output register; each cell advances when empty or its neighbor moves,
// so bubbles close up and in_stall rises only when the front stage is full and blocked.
module xtea_ctr_keystream_cipher_core #(
  parameter int unsigned ROUND_COUNT = xtea_ctr_pkg::ROUND_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  xtea_ctr_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output xtea_ctr_pkg::out_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [xtea_ctr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                         cfg_data
);
  import xtea_ctr_pkg::*;

  localparam int unsigned CELLS = 2 * ROUND_COUNT;

  key_t        key;
  logic [63:0] nonce;

  logic   front_valid;
  stage_t front_dn;
  logic   out_ready;

  logic   cell_valid [CELLS];
  logic   cell_ready [CELLS];
  stage_t cell_dn    [CELLS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      nonce <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY0:  key[0] <= cfg_data[31:0];
        CFG_KEY1:  key[1] <= cfg_data[31:0];
        CFG_KEY2:  key[2] <= cfg_data[31:0];
        CFG_KEY3:  key[3] <= cfg_data[31:0];
        CFG_NONCE: nonce  <= cfg_data;
        default: ;
      endcase
    end
  end

  xtea_ctr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .nonce      (nonce),
    .ready_next (cell_ready[0]),
    .valid      (front_valid),
    .dn         (front_dn)
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic   up_valid;
    stage_t up;
    logic   ready_next;

    if (i == 0) begin : g_first
      assign up_valid = front_valid;
      assign up       = front_dn;
    end else begin : g_mid
      assign up_valid = cell_valid[i-1];
      assign up       = cell_dn[i-1];
    end

    if (i == CELLS - 1) begin : g_last
      assign ready_next = out_ready;
    end else begin : g_link
      assign ready_next = cell_ready[i+1];
    end

    xtea_ctr_cell #(
      .STEP (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .key        (key),
      .up_valid   (up_valid),
      .up         (up),
      .ready_next (ready_next),
      .ready      (cell_ready[i]),
      .valid      (cell_valid[i]),
      .dn         (cell_dn[i])
    );
  end

  xtea_ctr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (cell_valid[CELLS-1]),
    .up        (cell_dn[CELLS-1]),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |-> out_data.out_byte == 8'd0)
    else $error("error result carries nonzero byte");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> front_valid && !cell_ready[0])
    else $error("input stalled with room in front stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !front_valid)
    else $error("pipeline not empty after reset");

endmodule
